@@ rtl/ffba_pkg.sv @@
package ffba_pkg;

    localparam int SIZE_W = 16;
    localparam int STAT_W = 2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOMEM = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_NEXT,
        S_SHUP,
        S_WNEW,
        S_SHDN,
        S_FIN
    } ffba_state_t;

endpackage

@@ rtl/ffba_req_if.sv @@
interface ffba_req_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [SIZE_W-1:0] request_size;
    logic [SIZE_W-1:0] block_address;

    modport source (output valid, kind, request_size, block_address, input ready);
    modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

@@ rtl/ffba_rsp_if.sv @@
interface ffba_rsp_if;
    import ffba_pkg::*;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] alloc_address;

    modport source (output valid, status, alloc_address, input ready);
    modport sink (input valid, status, alloc_address, output ready);
endinterface

@@ rtl/ffba_ram.sv @@
module ffba_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/first_fit_block_allocator_top.sv @@
// channel | dir | handshake   | payload
// req     | in  | valid/ready | kind, request_size, block_address
// rsp     | out | valid/ready | status, alloc_address
// cfg     | in  | cfg_we      | cfg_wdata (pool_size)
//
// one request at a time: a scan of the area table, one entry per cycle out of the
// table memory, then for a split or merge one shift pass of one entry per cycle.
// after reset the S_INIT state writes the initial free area before requests are taken.
// a result waits in the output register; a stalled rsp holds the block in its last step.
module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int MAX_AREAS = 64,
    parameter int ADDR_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    ffba_req_if.sink          req,
    ffba_rsp_if.source        rsp
);

    localparam int IW   = $clog2(MAX_AREAS);
    localparam int CNTW = $clog2(MAX_AREAS + 1);
    localparam int CW1  = CNTW + 1;
    localparam int WW   = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;
    localparam int EW   = ADDR_BITS + SIZE_W + 1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic                 free_mark;
    } entry_t;

    ffba_state_t          state_reg, state_next;
    logic [SIZE_W-1:0]    pool_reg, pool_next;
    logic [CNTW-1:0]      count_reg, count_next;
    logic [CNTW-1:0]      idx_reg, idx_next;
    logic [CNTW-1:0]      dst_reg, dst_next;
    logic [1:0]           shift_reg, shift_next;
    logic                 kind_reg, kind_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [SIZE_W-1:0]    where_reg, where_next;
    entry_t               prev_reg, prev_next;
    entry_t               cur_reg, cur_next;
    logic [STAT_W-1:0]    stat_reg, stat_next;
    logic [SIZE_W-1:0]    addr_reg, addr_next;
    logic                 ovalid_reg, ovalid_next;
    logic [STAT_W-1:0]    ostat_reg, ostat_next;
    logic [SIZE_W-1:0]    oaddr_reg, oaddr_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    entry_t               ram_wdata;
    logic [EW-1:0]        ram_rdata;
    entry_t               rd;
    logic [SIZE_W-1:0]    rest;
    logic [SIZE_W-1:0]    sumsz;
    logic                 nf, pf;
    logic [CNTW-1:0]      rm_dst;
    logic [1:0]           rm_k;

    ffba_ram #(.WIDTH(EW), .DEPTH(MAX_AREAS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd        = entry_t'(ram_rdata);
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid         = ovalid_reg;
    assign rsp.status        = ostat_reg;
    assign rsp.alloc_address = oaddr_reg;

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            pool_reg   <= 16'd4096;
            count_reg  <= CNTW'(1);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pool_reg   <= pool_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        dst_reg   <= dst_next;
        shift_reg <= shift_next;
        kind_reg  <= kind_next;
        size_reg  <= size_next;
        where_reg <= where_next;
        prev_reg  <= prev_next;
        cur_reg   <= cur_next;
        stat_reg  <= stat_next;
        addr_reg  <= addr_next;
        ostat_reg <= ostat_next;
        oaddr_reg <= oaddr_next;
    end

    // sequencer: scan, split, merge and shift passes
    always_comb
    begin
        state_next  = state_reg;
        pool_next   = pool_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        dst_next    = dst_reg;
        shift_next  = shift_reg;
        kind_next   = kind_reg;
        size_next   = size_reg;
        where_next  = where_reg;
        prev_next   = prev_reg;
        cur_next    = cur_reg;
        stat_next   = stat_reg;
        addr_next   = addr_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        oaddr_next  = oaddr_reg;
        ram_we      = 1'b0;
        ram_waddr   = IW'(idx_reg);
        ram_wdata   = '0;
        ram_raddr   = IW'(idx_reg + CNTW'(1));
        rest        = rd.size - size_reg;
        nf          = (CW1'(idx_reg) + CW1'(1) < CW1'(count_reg)) && rd.free_mark;
        pf          = (idx_reg != '0) && prev_reg.free_mark;
        sumsz       = cur_reg.size + (nf ? rd.size : '0);
        rm_dst      = idx_reg;
        rm_k        = 2'd1;

        // result leaves the output register
        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = '{start: '0, size: pool_reg, free_mark: 1'b1};
                count_next = CNTW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                ram_raddr = '0;
                if (req.valid)
                begin
                    kind_next  = req.kind;
                    size_next  = req.request_size;
                    where_next = req.block_address;
                    idx_next   = '0;
                    addr_next  = '0;
                    if (req.kind == KIND_ALLOC && req.request_size == '0)
                    begin
                        stat_next  = STAT_BAD;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                begin
                    stat_next  = (kind_reg == KIND_ALLOC) ? STAT_NOMEM : STAT_BAD;
                    state_next = S_FIN;
                end
                else if (kind_reg == KIND_ALLOC && rd.free_mark && rd.size >= size_reg)
                begin
                    if (rest != '0 && CW1'(count_reg) == CW1'(MAX_AREAS))
                    begin
                        stat_next  = STAT_FULL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = '{start: rd.start, size: size_reg, free_mark: 1'b0};
                        stat_next = STAT_OK;
                        addr_next = SIZE_W'(WW'(rd.start));
                        cur_next  = '{start: ADDR_BITS'(WW'(rd.start) + WW'(size_reg)),
                                      size: rest, free_mark: 1'b1};
                        if (rest == '0)
                        begin
                            state_next = S_FIN;
                        end
                        else if (CW1'(count_reg) > CW1'(idx_reg) + CW1'(1))
                        begin
                            dst_next   = count_reg;
                            ram_raddr  = IW'(count_reg - CNTW'(1));
                            state_next = S_SHUP;
                        end
                        else
                        begin
                            state_next = S_WNEW;
                        end
                    end
                end
                else if (kind_reg == KIND_FREE && !rd.free_mark
                         && WW'(rd.start) == WW'(where_reg))
                begin
                    cur_next   = rd;
                    state_next = S_NEXT;
                end
                else
                begin
                    prev_next = rd;
                    idx_next  = idx_reg + CNTW'(1);
                end
            end
            S_SHUP:
            begin
                ram_we    = 1'b1;
                ram_waddr = IW'(dst_reg);
                ram_wdata = rd;
                if (CW1'(dst_reg) == CW1'(idx_reg) + CW1'(2))
                begin
                    state_next = S_WNEW;
                end
                else
                begin
                    dst_next  = dst_reg - CNTW'(1);
                    ram_raddr = IW'(dst_reg - CNTW'(2));
                end
            end
            S_WNEW:
            begin
                ram_we     = 1'b1;
                ram_waddr  = IW'(idx_reg + CNTW'(1));
                ram_wdata  = cur_reg;
                count_next = count_reg + CNTW'(1);
                state_next = S_FIN;
            end
            S_NEXT:
            begin
                stat_next = STAT_OK;
                addr_next = '0;
                ram_we    = 1'b1;
                if (pf)
                begin
                    ram_waddr = IW'(idx_reg - CNTW'(1));
                    ram_wdata = '{start: prev_reg.start, size: prev_reg.size + sumsz,
                                  free_mark: 1'b1};
                    rm_dst    = idx_reg;
                    rm_k      = nf ? 2'd2 : 2'd1;
                end
                else
                begin
                    ram_wdata = '{start: cur_reg.start, size: sumsz, free_mark: 1'b1};
                    rm_dst    = idx_reg + CNTW'(1);
                    rm_k      = 2'd1;
                end
                if (!pf && !nf)
                begin
                    state_next = S_FIN;
                end
                else if (CW1'(rm_dst) + CW1'(rm_k) < CW1'(count_reg))
                begin
                    dst_next   = rm_dst;
                    shift_next = rm_k;
                    ram_raddr  = IW'(rm_dst + CNTW'(rm_k));
                    state_next = S_SHDN;
                end
                else
                begin
                    count_next = count_reg - CNTW'(rm_k);
                    state_next = S_FIN;
                end
            end
            S_SHDN:
            begin
                ram_we    = 1'b1;
                ram_waddr = IW'(dst_reg);
                ram_wdata = rd;
                if (CW1'(dst_reg) + CW1'(shift_reg) + CW1'(1) == CW1'(count_reg))
                begin
                    count_next = count_reg - CNTW'(shift_reg);
                    state_next = S_FIN;
                end
                else
                begin
                    dst_next  = dst_reg + CNTW'(1);
                    ram_raddr = IW'(dst_reg + CNTW'(shift_reg) + CNTW'(1));
                end
            end
            S_FIN:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = stat_reg;
                    oaddr_next  = addr_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // configuration write reinitializes the table
        if (cfg_we)
        begin
            pool_next  = cfg_wdata;
            ram_we     = 1'b1;
            ram_waddr  = '0;
            ram_wdata  = '{start: '0, size: cfg_wdata, free_mark: 1'b1};
            count_next = CNTW'(1);
        end
    end

endmodule

@@ bench/ffba_checker.sv @@
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int MAX_AREAS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    ffba_req_if               req,
    ffba_rsp_if               rsp,
    output int                fail_count,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] alloc_address;
    } grant_t;

    // shadow copy of the area table
    logic [SIZE_W-1:0] area_start [MAX_AREAS];
    logic [SIZE_W:0]   area_size  [MAX_AREAS];
    logic              area_free  [MAX_AREAS];
    int                area_cnt;
    logic [SIZE_W-1:0] pool_units;

    grant_t grant_q[$];

    task automatic report(input string msg);
        $display("ffba_checker: %0t %s", $realtime, msg);
        fail_count++;
    endtask

    function automatic void reset_areas(input logic [SIZE_W-1:0] units);
        pool_units    = units;
        area_start[0] = '0;
        area_size[0]  = {1'b0, units};
        area_free[0]  = 1'b1;
        area_cnt      = 1;
    endfunction

    function automatic void drop_area(input int idx);
        for (int c = idx; c + 1 < area_cnt; c++)
        begin
            area_start[c] = area_start[c+1];
            area_size[c]  = area_size[c+1];
            area_free[c]  = area_free[c+1];
        end
        area_cnt--;
    endfunction

    // first-fit allocate with split
    function automatic grant_t place_block(input logic [SIZE_W-1:0] units);
        grant_t      g;
        int          i;
        logic [SIZE_W:0] rest;
        g = '{status: STAT_OK, alloc_address: '0};
        if (units == 0)
        begin
            g.status = STAT_BAD;
            return g;
        end
        for (i = 0; i < area_cnt; i++)
            if (area_free[i] && area_size[i] >= {1'b0, units})
                break;
        if (i >= area_cnt)
        begin
            g.status = STAT_NOMEM;
            return g;
        end
        rest = area_size[i] - {1'b0, units};
        if (rest != 0 && area_cnt >= MAX_AREAS)
        begin
            g.status = STAT_FULL;
            return g;
        end
        area_size[i] = {1'b0, units};
        area_free[i] = 1'b0;
        if (rest != 0)
        begin
            for (int c = area_cnt; c > i + 1; c--)
            begin
                area_start[c] = area_start[c-1];
                area_size[c]  = area_size[c-1];
                area_free[c]  = area_free[c-1];
            end
            area_start[i+1] = area_start[i] + units;
            area_size[i+1]  = rest;
            area_free[i+1]  = 1'b1;
            area_cnt++;
        end
        g.alloc_address = area_start[i];
        return g;
    endfunction

    // release a used block and merge free neighbors
    function automatic grant_t release_block(input logic [SIZE_W-1:0] where);
        grant_t g;
        int     i;
        g = '{status: STAT_OK, alloc_address: '0};
        for (i = 0; i < area_cnt; i++)
            if (!area_free[i] && area_start[i] == where)
                break;
        if (i >= area_cnt)
        begin
            g.status = STAT_BAD;
            return g;
        end
        area_free[i] = 1'b1;
        if (i + 1 < area_cnt && area_free[i+1])
        begin
            area_size[i] = area_size[i] + area_size[i+1];
            drop_area(i + 1);
        end
        if (i > 0 && area_free[i-1])
        begin
            area_size[i-1] = area_size[i-1] + area_size[i];
            drop_area(i);
        end
        return g;
    endfunction

    // watch transfers and compare
    always @(posedge clk or negedge rst_n)
    begin
        grant_t got;
        grant_t want;
        if (!rst_n)
        begin
            reset_areas(16'd4096);
            grant_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_we)
                reset_areas(cfg_wdata);
            if (req.valid && req.ready)
            begin
                if (req.kind == KIND_ALLOC)
                    grant_q.push_back(place_block(req.request_size));
                else
                    grant_q.push_back(release_block(req.block_address));
            end
            if (rsp.valid && rsp.ready)
            begin
                got = '{status: rsp.status, alloc_address: rsp.alloc_address};
                if (grant_q.size() == 0)
                    report($sformatf("unexpected result status %0d addr %0d",
                                     got.status, got.alloc_address));
                else
                begin
                    want = grant_q.pop_front();
                    if (got.status !== want.status)
                        report($sformatf("status %0d, want %0d", got.status, want.status));
                    if (got.alloc_address !== want.alloc_address)
                        report($sformatf("alloc_address %0d, want %0d",
                                         got.alloc_address, want.alloc_address));
                end
            end
            outstanding = grant_q.size();
        end
    end

endmodule

@@ bench/first_fit_block_allocator_top_tb.sv @@
module first_fit_block_allocator_top_tb;
    import ffba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_AREAS = 64;
    localparam int SETTLE    = 2 * MAX_AREAS + 10;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;
    int                fail_count;
    int                outstanding;

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();

    first_fit_block_allocator_top #(
        .MAX_AREAS(MAX_AREAS),
        .ADDR_BITS(16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    ffba_checker #(.MAX_AREAS(MAX_AREAS)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    // stimulus state
    bit                idle_on = 1'b1;
    bit                hold_req = 1'b0;
    int                pool_now = 4096;
    logic              sent_kind[$];
    logic [SIZE_W-1:0] live_blocks[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("first_fit_block_allocator_top_tb failed");
        $finish;
    end

    // one request transfer, with random gaps ahead of it
    task automatic send_req(input logic k, input logic [SIZE_W-1:0] units,
                            input logic [SIZE_W-1:0] where);
        while (idle_on && $urandom_range(99) < 21)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= k;
        req_ch.request_size  <= units;
        req_ch.block_address <= where;
        do @(posedge clk); while (!req_ch.ready);
        sent_kind.push_back(k);
    endtask

    // drain, then rewrite pool_size
    task automatic set_pool(input logic [SIZE_W-1:0] units);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= units;
        @(posedge clk);
        cfg_we   <= 1'b0;
        pool_now = int'(units);
        live_blocks.delete();
    endtask

    // random mix of allocate/free traffic, well-formed and malformed
    task automatic random_phase(input int n);
        int                pick;
        int                idx;
        logic [SIZE_W-1:0] units;
        logic [SIZE_W-1:0] where;
        for (int j = 0; j < n; j++)
        begin
            pick  = int'($urandom_range(99));
            units = 16'($urandom);
            where = 16'($urandom);
            if (pick < 55)
            begin
                if (pool_now > 0)
                    units = 16'($urandom_range(1, pool_now / 8 + 1));
                send_req(KIND_ALLOC, units, where);
            end
            else if (pick < 60)
                send_req(KIND_ALLOC, (pick < 57) ? '0 : units, where);
            else if (pick < 92 && live_blocks.size() > 0)
            begin
                idx   = int'($urandom_range(live_blocks.size() - 1));
                where = live_blocks[idx];
                if (pick < 90)
                    live_blocks.delete(idx);
                send_req(KIND_FREE, units, where);
            end
            else
                send_req(KIND_FREE, units, where);
        end
    endtask

    // result side: random back-pressure, one long hold on request
    initial
    begin
        logic k;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (400)
                begin
                    rsp_ch.ready <= 1'b0;
                    @(posedge clk);
                end
            end
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 21);
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready && sent_kind.size() > 0)
            begin
                k = sent_kind.pop_front();
                if (k == KIND_ALLOC && rsp_ch.status == STAT_OK)
                    live_blocks.push_back(rsp_ch.alloc_address);
            end
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= KIND_ALLOC;
        req_ch.request_size  <= '0;
        req_ch.block_address <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset pool of 4096
        send_req(KIND_ALLOC, 16'd0, 16'hFFFF);
        send_req(KIND_ALLOC, 16'hFFFF, 16'd0);
        send_req(KIND_ALLOC, 16'd1, 16'h5A5A);
        send_req(KIND_ALLOC, 16'd4095, 16'hA5A5);
        send_req(KIND_ALLOC, 16'd1, 16'd0);
        send_req(KIND_FREE, 16'hFFFF, 16'd0);
        send_req(KIND_FREE, 16'd0, 16'd0);
        send_req(KIND_FREE, 16'd0, 16'd1);
        send_req(KIND_FREE, 16'd0, 16'hFFFF);
        send_req(KIND_ALLOC, 16'd4096, 16'd0);

        // fill the table with unit blocks until a split no longer fits
        set_pool(16'hFFFF);
        repeat (MAX_AREAS) send_req(KIND_ALLOC, 16'd1, 16'($urandom));
        send_req(KIND_ALLOC, 16'(16'hFFFF - (MAX_AREAS - 1)), 16'd0);
        send_req(KIND_FREE, 16'd0, 16'd5);
        send_req(KIND_FREE, 16'd0, 16'd4);

        // empty pool
        set_pool(16'd0);
        send_req(KIND_ALLOC, 16'd1, 16'd0);
        send_req(KIND_ALLOC, 16'd0, 16'd0);
        send_req(KIND_FREE, 16'd0, 16'd0);

        // random phases over several pool sizes
        set_pool(16'd1);
        random_phase(150);
        set_pool(16'd200);
        hold_req = 1'b1;
        random_phase(300);
        set_pool(16'hFFFF);
        idle_on = 1'b0;
        random_phase(300);
        idle_on = 1'b1;
        set_pool(16'd4096);
        random_phase(300);
        set_pool(16'($urandom_range(2, 1000)));
        random_phase(250);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("first_fit_block_allocator_top_tb passed");
        else
            $display("first_fit_block_allocator_top_tb failed");
        $finish;
    end

endmodule
